[hdl/ipalp_pkg.sv]
// ----------------------------------------------------------------------------
// ipalp_pkg
// Shared types and constants for the IP address literal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipalp_pkg;

  localparam int ZONE_NAME_LIMIT_DEF = 64;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] NO_COMPRESS = 4'hF;
  localparam logic [8:0] POISON      = 9'd256;
  localparam logic [8:0] OCTET_MAX   = 9'd255;

  typedef enum logic [1:0] {
    ST_PARSED    = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_NAMED     = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic        is_ipv6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] scope;
  } out_t;

endpackage

`default_nettype wire

[hdl/ip_address_literal_parser_unit.sv]
// ----------------------------------------------------------------------------
// ip_address_literal_parser_unit
// Parses an IPv4 or IPv6 address literal, one character per transfer.
// ----------------------------------------------------------------------------
// The result is registered and appears in the cycle after the transfer of the last character.
// Throughput: one character per cycle; parse state updates in a single pass.
// The output register decouples the sides; input stalls only when it is full
// and not being drained.
// Reset (rst_ni low, async) clears parse state and drops out_valid_o.
`default_nettype none

module ip_address_literal_parser_unit #(
  parameter int ZONE_NAME_LIMIT = ipalp_pkg::ZONE_NAME_LIMIT_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  ipalp_pkg::in_t     in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output ipalp_pkg::out_t    out_data_o
);

  localparam int ZLW = $clog2(ZONE_NAME_LIMIT + 1);
  localparam logic [ZLW-1:0] ZLIM = ZLW'(ZONE_NAME_LIMIT);

  typedef struct packed {
    logic [7:0]     cc;
    logic           sc;
    logic [1:0]     v4i;
    logic [8:0]     v4v;
    logic           v4s;
    logic [31:0]    v4a;
    logic           v4f;
    logic [127:0]   head;
    logic [127:0]   tail;
    logic [3:0]     gc;
    logic [3:0]     cpz;
    logic [15:0]    thv;
    logic [2:0]     tl;
    logic           thd;
    logic [31:0]    to;
    logic [8:0]     tv;
    logic [1:0]     ti;
    logic           ts;
    logic [1:0]     cr;
    logic           iz;
    logic [31:0]    zv;
    logic           zn;
    logic [ZLW-1:0] zl;
    logic           v6f;
  } st_t;

  localparam st_t ST_CLEAR = '{
    cpz: ipalp_pkg::NO_COMPRESS, zn: 1'b1, default: '0
  };

  st_t             st_q, st_d;
  logic            out_valid_q;
  ipalp_pkg::out_t out_q, res;
  logic            in_fire;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic st_t push_grp(input st_t s, input logic [31:0] g, input logic two);
    st_t r;
    r = s;
    if (s.cpz == ipalp_pkg::NO_COMPRESS) begin
      r.head = two ? {s.head[95:0], g} : {s.head[111:0], g[15:0]};
    end else begin
      r.tail = two ? {s.tail[95:0], g} : {s.tail[111:0], g[15:0]};
    end
    return r;
  endfunction

  function automatic st_t end_token(input st_t s);
    st_t r;
    r = s;
    if (s.tl != 3'd0) begin
      if (s.thd) begin
        if (s.gc > 4'd6 || !s.ts || s.tv > ipalp_pkg::OCTET_MAX || s.ti != 2'd3) begin
          r.v6f = 1'b1;
        end else begin
          r = push_grp(r, {s.to[23:0], s.tv[7:0]}, 1'b1);
          r.gc = s.gc + 4'd2;
        end
      end else begin
        if (s.tl > 3'd4 || s.gc >= 4'd8) begin
          r.v6f = 1'b1;
        end else begin
          r = push_grp(r, {16'h0, s.thv}, 1'b0);
          r.gc = s.gc + 4'd1;
        end
      end
      r.tl  = '0;
      r.thd = 1'b0;
      r.thv = '0;
      r.to  = '0;
      r.tv  = '0;
      r.ti  = '0;
      r.ts  = 1'b0;
    end
    return r;
  endfunction

  always_comb begin : step
    st_t          s;
    logic [7:0]   c;
    logic         dig;
    logic [3:0]   d;
    logic [4:0]   h;
    logic [11:0]  v12;
    logic [35:0]  z36;
    logic [7:0]   p;
    logic         named;
    logic [7:0]   sh;
    logic [127:0] addr;
    s   = st_q;
    c   = in_data_i.ch;
    dig = (c >= ipalp_pkg::CH_ZERO) && (c <= ipalp_pkg::CH_NINE);
    d   = 4'(c - ipalp_pkg::CH_ZERO);
    h   = hex_val(c);
    v12 = '0;
    z36 = '0;
    p   = '0;
    named = 1'b0;
    sh    = '0;
    addr  = '0;
    res   = '0;
    res.status = ipalp_pkg::ST_MALFORMED;

    if (c == ipalp_pkg::CH_COLON) s.sc = 1'b1;

    if (dig) begin
      v12 = {3'b0, s.v4v} * 12'd10 + {8'b0, d};
      if (v12 > 12'd255) begin
        s.v4f = 1'b1;
        s.v4v = ipalp_pkg::POISON;
      end else begin
        s.v4v = v12[8:0];
      end
      s.v4s = 1'b1;
    end else if (c == ipalp_pkg::CH_DOT) begin
      if (!s.v4s || s.v4i == 2'd3 || s.v4v > ipalp_pkg::OCTET_MAX) begin
        s.v4f = 1'b1;
      end else begin
        s.v4a = {s.v4a[23:0], s.v4v[7:0]};
        s.v4i = s.v4i + 2'd1;
        s.v4v = '0;
        s.v4s = 1'b0;
      end
    end else begin
      s.v4f = 1'b1;
    end

    if (st_q.iz) begin
      if (s.zl < ZLIM) s.zl = s.zl + ZLW'(1);
      if (s.zn) begin
        if (dig) begin
          z36 = {4'b0, s.zv} * 36'd10 + {32'b0, d};
          if (z36 > 36'hFFFFFFFF) s.v6f = 1'b1;
          else s.zv = z36[31:0];
        end else begin
          s.zn = 1'b0;
        end
      end
    end else if (c != ipalp_pkg::CH_PCT) begin
      p = s.cc;
      if (s.cc != 8'hFF) s.cc = s.cc + 8'd1;
      if (c == ipalp_pkg::CH_COLON) begin
        if (s.tl != 3'd0) begin
          if (s.thd) s.v6f = 1'b1;
          s = end_token(s);
          s.cr = 2'd1;
        end else if (s.cr == 2'd0) begin
          s.cr = 2'd1;
        end else if (s.cr == 2'd1) begin
          if (s.cpz != ipalp_pkg::NO_COMPRESS) s.v6f = 1'b1;
          else s.cpz = s.gc;
          s.cr = 2'd2;
        end else begin
          s.v6f = 1'b1;
        end
      end else begin
        if (s.cr == 2'd1 && p == 8'd1) s.v6f = 1'b1;
        s.cr = 2'd0;
        if (c == ipalp_pkg::CH_DOT) begin
          if (!s.ts || s.tv > ipalp_pkg::OCTET_MAX || s.ti == 2'd3) begin
            s.v6f = 1'b1;
          end else begin
            s.to = {s.to[23:0], s.tv[7:0]};
            s.tv = '0;
            s.ti = s.ti + 2'd1;
            s.ts = 1'b0;
          end
          s.thd = 1'b1;
        end else if (h[4]) begin
          s.v6f = 1'b1;
        end else begin
          s.thv = {s.thv[11:0], h[3:0]};
          if (dig) begin
            v12 = {3'b0, s.tv} * 12'd10 + {8'b0, d};
            if (s.tv > ipalp_pkg::OCTET_MAX || v12 > 12'd255) s.tv = ipalp_pkg::POISON;
            else s.tv = v12[8:0];
            s.ts = 1'b1;
          end else begin
            s.tv = ipalp_pkg::POISON;
          end
        end
        if (s.tl != 3'd7) s.tl = s.tl + 3'd1;
      end
    end

    if (!st_q.iz && (c == ipalp_pkg::CH_PCT || in_data_i.last)) begin
      if (s.cc < 8'd2) s.v6f = 1'b1;
      if (s.tl != 3'd0) s = end_token(s);
      else if (s.cr == 2'd1) s.v6f = 1'b1;
      if (s.cpz == ipalp_pkg::NO_COMPRESS) begin
        if (s.gc != 4'd8) s.v6f = 1'b1;
      end else if (s.gc >= 4'd8) begin
        s.v6f = 1'b1;
      end
    end
    if (!st_q.iz && c == ipalp_pkg::CH_PCT) s.iz = 1'b1;
    if (in_data_i.last && s.iz && s.zl == '0) s.v6f = 1'b1;

    if (s.sc) begin
      named = s.iz && !s.zn;
      if (named && s.zl >= ZLIM) s.v6f = 1'b1;
      if (!s.v6f) begin
        sh = 8'd8 - {5'b0, s.cpz[2:0]};
        if (s.cpz == ipalp_pkg::NO_COMPRESS) addr = s.head;
        else addr = (s.head << {sh[3:0], 4'b0}) | s.tail;
        if (sh[3]) addr = (s.cpz == ipalp_pkg::NO_COMPRESS) ? s.head : s.tail;
        res.addr_hi = addr[127:64];
        res.addr_lo = addr[63:0];
        res.is_ipv6 = 1'b1;
        res.status  = named ? ipalp_pkg::ST_NAMED : ipalp_pkg::ST_PARSED;
        res.scope   = (s.iz && !named) ? s.zv : 32'h0;
      end
    end else if (!s.v4f && s.v4s && s.v4i == 2'd3 && s.v4v <= ipalp_pkg::OCTET_MAX) begin
      res.status  = ipalp_pkg::ST_PARSED;
      res.addr_lo = {32'h0, s.v4a[23:0], s.v4v[7:0]};
    end

    st_d = in_data_i.last ? ST_CLEAR : s;
  end

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) st_q <= st_d;
      if (in_fire && in_data_i.last) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.last) out_q <= res;
  end

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.last |=> out_valid_o)
    else $error("no result after last character");
  a_mid_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_data_i.last && !out_valid_o |=> !out_valid_o)
    else $error("result without last character");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ipalp_pkg::ST_MALFORMED |->
    !out_data_o.is_ipv6 && out_data_o.addr_hi == 64'h0 && out_data_o.addr_lo == 64'h0
    && out_data_o.scope == 32'h0)
    else $error("malformed result carries data");
  a_v4_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_ipv6 |->
    out_data_o.addr_hi == 64'h0 && out_data_o.scope == 32'h0
    && out_data_o.addr_lo[63:32] == 32'h0 && out_data_o.status != ipalp_pkg::ST_NAMED)
    else $error("bad IPv4 result shape");
`endif

endmodule

`default_nettype wire
